/* rtl/core/bpa_pkg.sv */
// Shared types and constants of the bitmap page allocator.
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

    localparam int CMD_W      = 2;
    localparam int PADDR_W    = 32;
    localparam int ADDR_W     = 27;
    localparam int STATUS_W   = 2;
    localparam int FREE_W     = 15;
    localparam int OUT_DATA_W = 48;
    localparam int WORD_W     = 32;
    localparam int BIT_W      = 5;
    localparam int FWORD_W    = 15;
    localparam int PAGE_OFS_W = 12;
    localparam int WORD_SHIFT = 17;

    localparam logic [CMD_W-1:0] CMD_GEN_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POOL_ALLOC = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GEN_FREE   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_POOL_FREE  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OUT_RANGE = 2'd3;

    localparam logic [WORD_W-1:0] WORD_FULL = 32'hFFFF_FFFF;

    typedef struct packed {
        logic              room;
        logic [BIT_W-1:0]  zbit;
        logic              bit_set;
        logic [WORD_W-1:0] set_word;
        logic [WORD_W-1:0] clr_word;
    } word_info_t;

endpackage

`default_nettype wire

/* rtl/core/bpa_mem.sv */
// Bitmap word memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module bpa_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [AW-1:0]             waddr,
    input  wire logic [bpa_pkg::WORD_W-1:0] wdata,
    input  wire logic                      re,
    input  wire logic [AW-1:0]             raddr,
    output logic      [bpa_pkg::WORD_W-1:0] rdata
);
    import bpa_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/core/bpa_word_unit.sv */
// Shared word unit: full test, lowest zero bit search and bit set and clear.
`timescale 1ns / 1ps
`default_nettype none

module bpa_word_unit (
    input  wire logic [bpa_pkg::WORD_W-1:0] word,
    input  wire logic [bpa_pkg::BIT_W-1:0]  bit_sel,
    output bpa_pkg::word_info_t             info
);
    import bpa_pkg::*;

    logic [BIT_W-1:0] zbit;

    always_comb
    begin
        zbit = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (!word[i])
            begin
                zbit = BIT_W'(i);
            end
        end
    end

    always_comb
    begin
        info.room     = (word != WORD_FULL);
        info.zbit     = zbit;
        info.bit_set  = word[bit_sel];
        info.set_word = word | (WORD_W'(1) << zbit);
        info.clr_word = word & ~(WORD_W'(1) << bit_sel);
    end

endmodule

`default_nettype wire

/* rtl/core/bitmap_page_allocator_top.sv */
// Top level of the bitmap page allocator with its command sequencer.
//
// Commands arrive on the s_axis channel: tuser carries the command (general
// alloc, pool alloc, general free, pool free) and tdata the page byte address
// used by the frees. Each command gives exactly one result on the m_axis
// channel: allocated address, status and the count of free general pages.
// After reset the block clears the bitmap memory one word per cycle and
// keeps s_axis_tready low until that is done. The block handles one command
// at a time. A free inside the bitmap goes through one memory read, one check
// and write, the loading of the output register and the return to the ready
// state; a free outside the bitmap goes straight to the output register. An
// alloc examines one bitmap word at a time through the shared word unit
// (read, then test and set) and stops at the first word with room; words
// beyond the bitmap are skipped without a read. A failed general alloc walks
// the whole general pool. The result sits in an output register; when the
// receiver stalls, the next result waits in the sequencer and no new command
// is taken.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_page_allocator_top #(
    parameter int TOTAL_WORDS    = 1024,
    parameter int RESERVED_WORDS = 16,
    parameter int POOL_WORDS     = 16,
    parameter int GENERAL_WORDS  = 992
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // page_address
    input  wire logic [bpa_pkg::PADDR_W-1:0]    s_axis_tdata,
    // cmd
    input  wire logic [bpa_pkg::CMD_W-1:0]      s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // alloc_address [26:0], status [28:27], free_pages [43:29], zeros above
    output logic      [bpa_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import bpa_pkg::*;

    localparam int GENERAL_BASE  = RESERVED_WORDS + POOL_WORDS;
    localparam int GENERAL_PAGES = GENERAL_WORDS * 32;
    localparam int AW = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;
    localparam int SCAN_END = GENERAL_BASE + GENERAL_WORDS;
    localparam int WW = (SCAN_END > TOTAL_WORDS) ? $clog2(SCAN_END + 1)
                                                 : $clog2(TOTAL_WORDS + 1);
    localparam int OW = (GENERAL_WORDS > POOL_WORDS) ? $clog2(GENERAL_WORDS + 1)
                                                     : $clog2(POOL_WORDS + 1);
    localparam int HW = (GENERAL_WORDS > 1) ? $clog2(GENERAL_WORDS) : 1;
    localparam int UW = $clog2(GENERAL_PAGES + 1);

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_SCAN_RD  = 3'd2;
    localparam logic [2:0] S_SCAN_CHK = 3'd3;
    localparam logic [2:0] S_FREE_RD  = 3'd4;
    localparam logic [2:0] S_FREE_CHK = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [AW-1:0]         clr_cnt_reg, clr_cnt_next;
    logic [CMD_W-1:0]      cmd_reg, cmd_next;
    logic [FWORD_W-1:0]    fword_reg, fword_next;
    logic [BIT_W-1:0]      fbit_reg, fbit_next;
    logic [OW-1:0]         off_reg, off_next;
    logic [OW-1:0]         cnt_reg, cnt_next;
    logic [HW-1:0]         hint_reg, hint_next;
    logic [UW-1:0]         used_reg, used_next;
    logic [ADDR_W-1:0]     res_addr_reg, res_addr_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [WORD_W-1:0]     mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [WORD_W-1:0]     mem_rdata;
    word_info_t            winfo;

    logic                  accept;
    logic                  gen_scan;
    logic [WW-1:0]         scan_base;
    logic [OW-1:0]         scan_count;
    logic [WW-1:0]         scan_w;
    logic                  scan_in_range;
    logic [OW-1:0]         off_inc;
    logic [OW-1:0]         cnt_inc;
    logic [31:0]           alloc_wide;
    logic [FWORD_W-1:0]    fword_in;
    logic [FWORD_W-1:0]    fword_rel;
    logic [31:0]           free_wide;

    bpa_mem #(
        .DEPTH (TOTAL_WORDS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bpa_word_unit u_word (
        .word    (mem_rdata),
        .bit_sel (fbit_reg),
        .info    (winfo)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign gen_scan      = (cmd_reg == CMD_GEN_ALLOC);
    assign scan_base     = gen_scan ? WW'(GENERAL_BASE) : WW'(RESERVED_WORDS);
    assign scan_count    = gen_scan ? OW'(GENERAL_WORDS) : OW'(POOL_WORDS);
    assign scan_w        = scan_base + WW'(off_reg);
    assign scan_in_range = (scan_w < WW'(TOTAL_WORDS));
    assign off_inc       = ((off_reg + OW'(1)) == scan_count) ? '0 : off_reg + OW'(1);
    assign cnt_inc       = cnt_reg + OW'(1);
    assign alloc_wide    = (32'(scan_w) << WORD_SHIFT) | (32'(winfo.zbit) << PAGE_OFS_W);
    assign fword_in      = s_axis_tdata[PADDR_W-1:WORD_SHIFT];
    assign fword_rel     = fword_reg - FWORD_W'(GENERAL_BASE);
    assign free_wide     = 32'(GENERAL_PAGES) - 32'(used_reg);

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        cmd_next        = cmd_reg;
        fword_next      = fword_reg;
        fbit_next       = fbit_reg;
        off_next        = off_reg;
        cnt_next        = cnt_reg;
        hint_next       = hint_reg;
        used_next       = used_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_data_next     = m_data_reg;
        mem_we          = 1'b0;
        mem_waddr       = AW'(scan_w);
        mem_wdata       = winfo.set_word;
        mem_re          = 1'b0;
        mem_raddr       = AW'(scan_w);

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
                if (clr_cnt_reg == AW'(TOTAL_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next      = s_axis_tuser;
                    fword_next    = fword_in;
                    fbit_next     = s_axis_tdata[WORD_SHIFT-1:PAGE_OFS_W];
                    cnt_next      = '0;
                    res_addr_next = '0;
                    off_next      = (s_axis_tuser == CMD_GEN_ALLOC) ? OW'(hint_reg) : '0;
                    if (s_axis_tuser == CMD_GEN_ALLOC || s_axis_tuser == CMD_POOL_ALLOC)
                    begin
                        state_next = S_SCAN_RD;
                    end
                    else if (fword_in >= FWORD_W'(TOTAL_WORDS))
                    begin
                        res_status_next = ST_OUT_RANGE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FREE_RD;
                    end
                end
            end
            S_SCAN_RD:
            begin
                if (scan_in_range)
                begin
                    mem_re     = 1'b1;
                    state_next = S_SCAN_CHK;
                end
                else if (cnt_inc == scan_count)
                begin
                    res_status_next = ST_NO_FREE;
                    res_addr_next   = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    off_next = off_inc;
                    cnt_next = cnt_inc;
                end
            end
            S_SCAN_CHK:
            begin
                if (winfo.room)
                begin
                    mem_we          = 1'b1;
                    res_addr_next   = alloc_wide[ADDR_W-1:0];
                    res_status_next = ST_OK;
                    state_next      = S_DONE;
                    if (gen_scan)
                    begin
                        hint_next = HW'(off_reg);
                        if (used_reg < UW'(GENERAL_PAGES))
                        begin
                            used_next = used_reg + UW'(1);
                        end
                    end
                end
                else if (cnt_inc == scan_count)
                begin
                    res_status_next = ST_NO_FREE;
                    res_addr_next   = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    off_next   = off_inc;
                    cnt_next   = cnt_inc;
                    state_next = S_SCAN_RD;
                end
            end
            S_FREE_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(fword_reg);
                state_next = S_FREE_CHK;
            end
            S_FREE_CHK:
            begin
                mem_waddr  = AW'(fword_reg);
                mem_wdata  = winfo.clr_word;
                state_next = S_DONE;
                if (!winfo.bit_set)
                begin
                    res_status_next = ST_NOT_ALLOC;
                end
                else
                begin
                    mem_we          = 1'b1;
                    res_status_next = ST_OK;
                    if (cmd_reg == CMD_GEN_FREE)
                    begin
                        if (fword_reg >= FWORD_W'(GENERAL_BASE) &&
                            fword_rel < FWORD_W'(GENERAL_WORDS))
                        begin
                            hint_next = HW'(fword_rel);
                        end
                        if (used_reg != '0)
                        begin
                            used_next = used_reg - UW'(1);
                        end
                    end
                end
            end
            S_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{(OUT_DATA_W - ADDR_W - STATUS_W - FREE_W){1'b0}},
                                    free_wide[FREE_W-1:0], res_status_reg, res_addr_reg};
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            hint_reg    <= '0;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            hint_reg    <= hint_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        fword_reg      <= fword_next;
        fbit_reg       <= fbit_next;
        off_reg        <= off_next;
        cnt_reg        <= cnt_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
    end

endmodule

`default_nettype wire

/* rtl/core/bpa_checker.sv */
// Port checker of the bitmap page allocator and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bpa_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    input  wire logic                          s_axis_tready,
    input  wire logic [bpa_pkg::PADDR_W-1:0]    s_axis_tdata,
    input  wire logic [bpa_pkg::CMD_W-1:0]      s_axis_tuser,
    input  wire logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic [bpa_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import bpa_pkg::*;

    logic [ADDR_W-1:0]   out_addr;
    logic [STATUS_W-1:0] out_status;

    assign out_addr   = m_axis_tdata[ADDR_W-1:0];
    assign out_status = m_axis_tdata[ADDR_W+STATUS_W-1:ADDR_W];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("Result dropped while the receiver stalled.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("A second command was taken while one was in progress.");

    a_fail_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_status != ST_OK |-> out_addr == '0)
        else $error("Address is not zero on a failed command.");

    a_addr_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> out_addr[PAGE_OFS_W-1:0] == '0)
        else $error("Allocated address is not page aligned.");

endmodule

bind bitmap_page_allocator_top bpa_checker u_bpa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
